### rtl/core/set_assoc_writeback_cache_core_macros.svh
// Assertion macros for the set-associative write-back cache core
`ifndef SET_ASSOC_WRITEBACK_CACHE_CORE_MACROS_SVH
`define SET_ASSOC_WRITEBACK_CACHE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on the core clock, disabled while reset is asserted
`define SAC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Check an implication: condition now, consequence in the next cycle
`define SAC_ASSERT_NEXT(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error(msg);
`else
`define SAC_ASSERT(lbl, prop, msg)
`define SAC_ASSERT_NEXT(lbl, cond, cons, msg)
`endif
`endif

### rtl/core/sac_pkg.sv
// Shared codes and constants of the set-associative write-back cache
package sac_pkg;
    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_FILL  = 2'd2;

    localparam logic [1:0] KIND_READ = 2'd0;
    localparam logic [1:0] KIND_WB   = 2'd1;
    localparam logic [1:0] KIND_REQ  = 2'd2;
    localparam logic [1:0] KIND_DONE = 2'd3;

    localparam logic [15:0] LFSR_TAPS  = 16'hB400;
    localparam logic [15:0] RESET_SEED = 16'd44257;
    localparam logic [7:0]  BYTE_MASK  = 8'hFF;
    localparam logic [2:0]  MAX_LEN    = 3'd4;
endpackage

### rtl/core/set_assoc_writeback_cache_core.sv
// Set-associative write-back, write-allocate cache with random replacement
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries cpu reads, cpu writes and
//   fill words. Output channel (o_out_valid / i_out_ready) carries read data,
//   write-back words, fill requests and write-done results; o_last marks the
//   final result of an input transaction.
//   Configuration: i_cfg_we loads i_cfg_data into the victim LFSR at once.
//   Sequence: a hit read or write does a lookup, then moves each byte through
//   the single data memory port; a write then reads and rewrites the metadata
//   row of each touched line to set the dirty bit. A line crossing adds a
//   second lookup. On a miss, a dirty victim is written back word by word,
//   then the fill request is issued; the fill words are taken one per accepted
//   input, and the access resumes after the last one.
//   Reset: a clearing pass writes every set's metadata row to zero, one set a
//   cycle; o_in_ready stays low during the pass.
//   Stall: results wait in one output register; the core stops when it needs
//   to issue a new result while that register is still held.
//   SETS, WAYS and LINE_BYTES are taken as powers of two.
module set_assoc_writeback_cache_core #(
    parameter int SETS       = 4096,
    parameter int WAYS       = 16,
    parameter int LINE_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_address,
    input  logic [2:0]  i_length,
    input  logic [31:0] i_write_data,
    input  logic [31:0] i_fill_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_result_kind,
    output logic [31:0] o_mem_address,
    output logic [31:0] o_out_data,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data
);
    import sac_pkg::*;
    `include "set_assoc_writeback_cache_core_macros.svh"

    localparam int OFF_W      = $clog2(LINE_BYTES);
    localparam int WRD_W      = OFF_W - 2;
    localparam int LINE_WORDS = LINE_BYTES / 4;
    localparam int SET_W      = $clog2(SETS);
    localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int LN_W       = 32 - OFF_W;
    localparam int TAG_W      = LN_W - SET_W;
    localparam int DA_W       = SET_W + WAY_W + WRD_W;

    localparam logic [3:0] ST_CLR  = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_LOOK = 4'd2;
    localparam logic [3:0] ST_CMP  = 4'd3;
    localparam logic [3:0] ST_WBR  = 4'd4;
    localparam logic [3:0] ST_WBE  = 4'd5;
    localparam logic [3:0] ST_REQ  = 4'd6;
    localparam logic [3:0] ST_FRD  = 4'd7;
    localparam logic [3:0] ST_FMD  = 4'd8;
    localparam logic [3:0] ST_DRD  = 4'd9;
    localparam logic [3:0] ST_DWR  = 4'd10;
    localparam logic [3:0] ST_DONE = 4'd11;

    typedef struct packed {
        logic [WAYS-1:0][TAG_W-1:0] tag;
        logic [WAYS-1:0]            dirty;
        logic [WAYS-1:0]            valid;
    } t_meta;

    // memories
    t_meta       meta_mem [SETS];
    logic [31:0] data_mem [SETS * (1 << WAY_W) * LINE_WORDS];

    // registers
    logic [3:0]       r_state, n_state;
    logic [SET_W-1:0] r_clr, n_clr;
    logic             r_busy, n_busy;
    logic [15:0]      r_lfsr, n_lfsr;
    logic             r_ov, n_ov;
    logic             r_wr, n_wr;
    logic             r_two, n_two;
    logic             r_cur, n_cur;
    logic [2:0]       r_len, n_len;
    logic [OFF_W-1:0] r_off, n_off;
    logic [31:0]      r_wd, n_wd;
    logic [LN_W-1:0]  r_ln [2];
    logic [LN_W-1:0]  n_ln [2];
    logic [WAY_W-1:0] r_way [2];
    logic [WAY_W-1:0] n_way [2];
    logic [TAG_W-1:0] r_vtag, n_vtag;
    logic [WRD_W-1:0] r_wi, n_wi;
    logic [WRD_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_bi, n_bi;
    logic [31:0]      r_val, n_val;
    logic             r_dk, n_dk;
    t_meta            r_meta, n_meta;
    logic [1:0]       r_kind, n_kind;
    logic [31:0]      r_maddr, n_maddr;
    logic [31:0]      r_odata, n_odata;
    logic             r_last, n_last;
    t_meta            r_mq;
    logic [31:0]      r_dq;

    // memory controls
    logic             m_we, m_re;
    logic [SET_W-1:0] m_addr;
    t_meta            m_wd;
    logic             d_we, d_re;
    logic [DA_W-1:0]  d_addr;
    logic [31:0]      d_wd;

    // combinational helpers
    logic             out_free;
    logic             in_acc;
    logic [2:0]       in_len;
    logic [LN_W-1:0]  in_ln;
    logic [OFF_W:0]   in_end;
    logic             hit;
    logic [WAY_W-1:0] hit_way;
    logic             any_inv;
    logic [WAY_W-1:0] inv_way;
    logic [15:0]      lfsr_step;
    logic [WAY_W-1:0] victim;
    logic [TAG_W-1:0] cur_tag;
    logic [SET_W-1:0] cur_set;
    logic [OFF_W:0]   bpos;
    logic             bk;
    logic [1:0]       bsh;
    logic [7:0]       rbyte;
    logic [7:0]       wbyte;
    logic [31:0]      mod_word;
    logic [SET_W-1:0] bset;
    logic [DA_W-1:0]  baddr;
    t_meta            meta_fill;
    t_meta            meta_dirty;

    assign out_free    = !r_ov || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_ov;
    assign o_result_kind = r_kind;
    assign o_mem_address = r_maddr;
    assign o_out_data    = r_odata;
    assign o_last        = r_last;

    // decode the incoming access
    assign in_len = (i_length > MAX_LEN) ? MAX_LEN : i_length;
    assign in_ln  = i_address[31:OFF_W];
    assign in_end = (OFF_W+1)'(i_address[OFF_W-1:0]) + (OFF_W+1)'(in_len);

    assign cur_set = r_ln[r_cur][SET_W-1:0];
    assign cur_tag = r_ln[r_cur][LN_W-1:SET_W];

    // search the set row for a hit and for the lowest free way
    always_comb begin
        hit     = 1'b0;
        hit_way = '0;
        any_inv = 1'b0;
        inv_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (r_mq.valid[w] && (r_mq.tag[w] == cur_tag)) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!r_mq.valid[w]) begin
                any_inv = 1'b1;
                inv_way = WAY_W'(w);
            end
        end
    end

    // step the victim LFSR and pick the way
    assign lfsr_step = {1'b0, r_lfsr[15:1]} ^ (r_lfsr[0] ? LFSR_TAPS : 16'd0);
    assign victim    = any_inv ? inv_way : ((WAYS == 1) ? '0 : lfsr_step[WAY_W-1:0]);

    // locate the current byte of the completing access
    assign bpos     = (OFF_W+1)'(r_off) + (OFF_W+1)'(r_bi);
    assign bk       = bpos[OFF_W];
    assign bsh      = bpos[1:0];
    assign bset     = r_ln[bk][SET_W-1:0];
    assign baddr    = {bset, r_way[bk], bpos[OFF_W-1:2]};
    assign rbyte    = 8'(r_dq >> {bsh, 3'b000});
    assign wbyte    = 8'(r_wd >> {r_bi, 3'b000});
    assign mod_word = (r_dq & ~(32'(BYTE_MASK) << {bsh, 3'b000}))
                    | (32'(wbyte) << {bsh, 3'b000});

    // install the filled line, and mark a written line dirty
    always_comb begin
        meta_fill = r_meta;
        meta_fill.valid[r_way[r_cur]] = 1'b1;
        meta_fill.dirty[r_way[r_cur]] = 1'b0;
        meta_fill.tag[r_way[r_cur]]   = cur_tag;
        meta_dirty = r_mq;
        meta_dirty.dirty[r_way[r_dk]] = 1'b1;
    end

    // sequence the accesses
    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_busy  = r_busy;
        n_lfsr  = r_lfsr;
        n_ov    = r_ov && !i_out_ready;
        n_wr    = r_wr;
        n_two   = r_two;
        n_cur   = r_cur;
        n_len   = r_len;
        n_off   = r_off;
        n_wd    = r_wd;
        n_ln    = r_ln;
        n_way   = r_way;
        n_vtag  = r_vtag;
        n_wi    = r_wi;
        n_cnt   = r_cnt;
        n_bi    = r_bi;
        n_val   = r_val;
        n_dk    = r_dk;
        n_meta  = r_meta;
        n_kind  = r_kind;
        n_maddr = r_maddr;
        n_odata = r_odata;
        n_last  = r_last;
        m_we    = 1'b0;
        m_re    = 1'b0;
        m_addr  = cur_set;
        m_wd    = r_meta;
        d_we    = 1'b0;
        d_re    = 1'b0;
        d_addr  = baddr;
        d_wd    = mod_word;

        unique case (r_state)
            ST_CLR: begin
                m_we   = 1'b1;
                m_addr = r_clr;
                m_wd   = '0;
                n_clr  = r_clr + 1'b1;
                if (r_clr == SET_W'(SETS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    if ((i_action == ACT_READ || i_action == ACT_WRITE) && !r_busy) begin
                        n_wr    = (i_action == ACT_WRITE);
                        n_len   = in_len;
                        n_off   = i_address[OFF_W-1:0];
                        n_wd    = i_write_data;
                        n_ln[0] = in_ln;
                        n_ln[1] = in_ln + 1'b1;
                        n_two   = (in_end > (OFF_W+1)'(LINE_BYTES));
                        n_cur   = 1'b0;
                        n_bi    = '0;
                        n_val   = '0;
                        n_dk    = 1'b0;
                        n_state = ST_LOOK;
                    end else if (i_action == ACT_FILL && r_busy) begin
                        d_we   = 1'b1;
                        d_addr = {cur_set, r_way[r_cur], r_cnt};
                        d_wd   = i_fill_word;
                        n_cnt  = r_cnt + 1'b1;
                        if (r_cnt == WRD_W'(LINE_WORDS - 1)) begin
                            m_we   = 1'b1;
                            m_wd   = meta_fill;
                            n_busy = 1'b0;
                            n_cur  = 1'b1;
                            if (!r_cur && r_two) begin
                                n_state = ST_LOOK;
                            end else if (r_len != 3'd0) begin
                                n_state = ST_FRD;
                            end else begin
                                n_state = ST_DONE;
                            end
                        end
                    end
                end
            end
            ST_LOOK: begin
                m_re    = 1'b1;
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (hit) begin
                    n_way[r_cur] = hit_way;
                    n_cur        = 1'b1;
                    if (!r_cur && r_two) begin
                        n_state = ST_LOOK;
                    end else if (r_len != 3'd0) begin
                        n_state = ST_FRD;
                    end else begin
                        n_state = ST_DONE;
                    end
                end else begin
                    if (!any_inv) begin
                        n_lfsr = lfsr_step;
                    end
                    n_way[r_cur] = victim;
                    n_meta = r_mq;
                    n_meta.valid[victim] = 1'b0;
                    n_meta.dirty[victim] = 1'b0;
                    n_vtag = r_mq.tag[victim];
                    n_wi   = '0;
                    if (r_mq.valid[victim] && r_mq.dirty[victim]) begin
                        n_state = ST_WBR;
                    end else begin
                        n_state = ST_REQ;
                    end
                end
            end
            ST_WBR: begin
                d_re    = 1'b1;
                d_addr  = {cur_set, r_way[r_cur], r_wi};
                n_state = ST_WBE;
            end
            ST_WBE: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_kind  = KIND_WB;
                    n_maddr = {r_vtag, cur_set, r_wi, 2'b00};
                    n_odata = r_dq;
                    n_last  = 1'b0;
                    n_wi    = r_wi + 1'b1;
                    n_state = (r_wi == WRD_W'(LINE_WORDS - 1)) ? ST_REQ : ST_WBR;
                end
            end
            ST_REQ: begin
                if (out_free) begin
                    m_we    = 1'b1;
                    n_ov    = 1'b1;
                    n_kind  = KIND_REQ;
                    n_maddr = {r_ln[r_cur], OFF_W'(0)};
                    n_odata = '0;
                    n_last  = 1'b1;
                    n_cnt   = '0;
                    n_busy  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_FRD: begin
                d_re    = 1'b1;
                n_state = ST_FMD;
            end
            ST_FMD: begin
                if (r_wr) begin
                    d_we = 1'b1;
                end else begin
                    n_val = r_val | (32'(rbyte) << {r_bi, 3'b000});
                end
                n_bi = r_bi + 1'b1;
                if (r_bi == 2'(r_len - 3'd1)) begin
                    n_state = r_wr ? ST_DRD : ST_DONE;
                end else begin
                    n_state = ST_FRD;
                end
            end
            ST_DRD: begin
                m_re    = 1'b1;
                m_addr  = r_ln[r_dk][SET_W-1:0];
                n_state = ST_DWR;
            end
            ST_DWR: begin
                m_we   = 1'b1;
                m_addr = r_ln[r_dk][SET_W-1:0];
                m_wd   = meta_dirty;
                n_dk   = 1'b1;
                n_state = (!r_dk && r_two) ? ST_DRD : ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_kind  = r_wr ? KIND_DONE : KIND_READ;
                    n_maddr = '0;
                    n_odata = r_wr ? 32'd0 : r_val;
                    n_last  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // load the seed on a configuration write
        if (i_cfg_we) begin
            n_lfsr = i_cfg_data;
        end
    end

    // hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_clr   <= '0;
            r_busy  <= 1'b0;
            r_lfsr  <= RESET_SEED;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_busy  <= n_busy;
            r_lfsr  <= n_lfsr;
            r_ov    <= n_ov;
        end
    end

    // hold access and result payload
    always_ff @(posedge i_clk) begin
        r_wr    <= n_wr;
        r_two   <= n_two;
        r_cur   <= n_cur;
        r_len   <= n_len;
        r_off   <= n_off;
        r_wd    <= n_wd;
        r_ln    <= n_ln;
        r_way   <= n_way;
        r_vtag  <= n_vtag;
        r_wi    <= n_wi;
        r_cnt   <= n_cnt;
        r_bi    <= n_bi;
        r_val   <= n_val;
        r_dk    <= n_dk;
        r_meta  <= n_meta;
        r_kind  <= n_kind;
        r_maddr <= n_maddr;
        r_odata <= n_odata;
        r_last  <= n_last;
    end

    // set metadata memory
    always_ff @(posedge i_clk) begin
        if (m_we) begin
            meta_mem[m_addr] <= m_wd;
        end
        if (m_re) begin
            r_mq <= meta_mem[m_addr];
        end
    end

    // line data memory
    always_ff @(posedge i_clk) begin
        if (d_we) begin
            data_mem[d_addr] <= d_wd;
        end
        if (d_re) begin
            r_dq <= data_mem[d_addr];
        end
    end

    `SAC_ASSERT_NEXT(a_req_waits_fill, (r_state == ST_REQ) && out_free,
        r_busy && (r_state == ST_IDLE), "fill request did not enter the fill wait")
    `SAC_ASSERT(a_busy_in_idle, r_busy |-> (r_state == ST_IDLE),
        "fill wait outside the idle state")
    `SAC_ASSERT(a_last_kind, (r_ov && r_last) |-> (r_kind != KIND_WB),
        "write-back word marked as last")
endmodule
